// File: rtl/urm_pkg.sv
// Shared constants, types and codes for the ultrasonic ranger median block.
package urm_pkg;

    localparam int MAX_SAMPLES = 8;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DIST_W      = 11;
    localparam int TICK_W      = 17;
    localparam int TMO_W       = 16;
    localparam int SC_W        = 4;
    localparam int PROD_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 1'b1;

    localparam logic [SC_W-1:0]  SAMPLE_COUNT_RST = 4'd5;
    localparam logic [TMO_W-1:0] TIMEOUT_RST      = 16'd30000;

    localparam logic [TICK_W-1:0] TRIG_LOW_TICKS  = 17'd2;
    localparam logic [TICK_W-1:0] TRIG_HIGH_TICKS = 17'd10;
    localparam logic [TICK_W-1:0] GAP_TICKS       = 17'd1000;

    // Division by 58 as a multiply by ceil(2^21/58) and a shift; exact for
    // every 16-bit dividend.
    localparam logic [TMO_W-1:0] DIV58_MUL   = 16'd36158;
    localparam int               DIV58_SHIFT = 21;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TRIG_LOW,
        PH_TRIG_HIGH,
        PH_WAIT_RISE,
        PH_HIGH,
        PH_GAP
    } t_phase;

    typedef enum logic [2:0] {
        HS_IDLE,
        HS_EXEC,
        HS_INS,
        HS_MED,
        HS_OUT
    } t_hs;

    // Outcome of one tick, handed from the sequencer to the top level.
    typedef struct packed {
        logic trig;
        logic done;
        logic store;
        logic clear;
    } t_meas;

endpackage

// File: rtl/urm_cell.sv
// One cell of the sorted sample row: holds a distance and shifts right on insertion.
module urm_cell (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [urm_pkg::DIST_W-1:0] i_d,
    input  logic                       i_occ,
    input  logic                       i_at_end,
    input  logic                       i_left_gt,
    input  logic [urm_pkg::DIST_W-1:0] i_left_val,
    output logic                       o_gt,
    output logic [urm_pkg::DIST_W-1:0] o_val
);
    import urm_pkg::*;

    logic [DIST_W-1:0] r_val;
    logic [DIST_W-1:0] n_val;

    // An occupied cell holding a larger value than the new one must move.
    assign o_gt  = i_occ && (r_val > i_d);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (o_gt || i_at_end) begin
            n_val = i_left_gt ? i_left_val : i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_val <= n_val;
        end
    end

endmodule

// File: rtl/urm_seq.sv
// Measurement sequencer: trigger pulse, echo timing, burst counting, distance product.
module urm_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_start,
    input  logic                      i_echo,
    input  logic [urm_pkg::SC_W-1:0]  i_sample_count,
    input  logic [urm_pkg::TMO_W-1:0] i_timeout,
    output urm_pkg::t_meas            o_meas,
    output logic [urm_pkg::DIST_W-1:0] o_dist
);
    import urm_pkg::*;

    t_phase              r_phase, n_phase;
    logic [TICK_W-1:0]   r_tick,  n_tick;
    logic [SC_W-1:0]     r_sidx,  n_sidx;
    t_meas               r_meas,  n_meas;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   w_prod;
    logic [TICK_W-1:0]   w_inc;
    logic [TICK_W-1:0]   w_tmo;
    logic [SC_W-1:0]     w_len;
    logic [SC_W-1:0]     w_sidx_nx;
    logic                w_end;
    logic                w_ok;

    assign w_inc     = TICK_W'(r_tick + 1'b1);
    assign w_tmo     = {1'b0, i_timeout};
    assign w_sidx_nx = SC_W'(r_sidx + 1'b1);
    // Duration times the reciprocal of 58; only used when the high phase ends
    // inside the timeout, so the count fits 16 bits.
    assign w_prod    = PROD_W'(r_tick[TMO_W-1:0]) * PROD_W'(DIV58_MUL);

    always_comb begin
        if (i_sample_count == '0) begin
            w_len = SC_W'(1);
        end else if (i_sample_count > SC_W'(MAX_SAMPLES)) begin
            w_len = SC_W'(MAX_SAMPLES);
        end else begin
            w_len = i_sample_count;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_sidx  = r_sidx;
        n_meas  = '0;
        w_end   = 1'b0;
        w_ok    = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_sidx       = '0;
                    n_tick       = '0;
                    n_phase      = PH_TRIG_LOW;
                    n_meas.clear = 1'b1;
                end
            end
            PH_TRIG_LOW: begin
                n_tick = w_inc;
                if (w_inc >= TRIG_LOW_TICKS) begin
                    n_tick  = '0;
                    n_phase = PH_TRIG_HIGH;
                end
            end
            PH_TRIG_HIGH: begin
                n_meas.trig = 1'b1;
                n_tick      = w_inc;
                if (w_inc >= TRIG_HIGH_TICKS) begin
                    n_tick  = '0;
                    n_phase = PH_WAIT_RISE;
                end
            end
            PH_WAIT_RISE: begin
                if (!i_echo) begin
                    n_tick = w_inc;
                    w_end  = (w_inc > w_tmo);
                end else begin
                    // The rising tick is the first high tick.
                    n_tick  = TICK_W'(1);
                    n_phase = PH_HIGH;
                    w_end   = (w_tmo == '0);
                end
            end
            PH_HIGH: begin
                if (i_echo) begin
                    n_tick = w_inc;
                    w_end  = (w_inc > w_tmo);
                end else begin
                    w_end = 1'b1;
                    w_ok  = 1'b1;
                end
            end
            PH_GAP: begin
                n_tick = w_inc;
                if (w_inc >= GAP_TICKS) begin
                    n_tick  = '0;
                    n_phase = PH_TRIG_LOW;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = '0;
            end
        endcase

        if (w_end) begin
            n_sidx       = w_sidx_nx;
            n_tick       = '0;
            n_meas.store = w_ok;
            if (w_sidx_nx >= w_len) begin
                n_phase     = PH_IDLE;
                n_meas.done = 1'b1;
            end else begin
                n_phase = PH_GAP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_sidx  <= '0;
            r_meas  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_sidx  <= n_sidx;
            r_meas  <= n_meas;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prod <= w_prod;
        end
    end

    assign o_meas = r_meas;
    assign o_dist = r_prod[DIV58_SHIFT +: DIST_W];

endmodule

// File: rtl/ultrasonic_ranger_median_top.sv
// Top level of the ultrasonic ranger with a median filter over a measurement burst.
//
// Each input item is one microsecond tick carrying the sampled echo level and a
// start request; each item yields exactly one result item with the trigger level
// for that tick, a done flag, the median distance in centimeters and a no-echo
// flag. A start request in idle launches a burst of sample_count measurements
// (zero counts as one, values above eight saturate at eight). Each measurement
// drives the trigger low for two ticks and high for ten, waits for the echo to
// rise and times the high phase, both bounded by timeout_us, and turns the high
// time into centimeters by dividing by 58. Nonzero distances are inserted into
// a row of cells that keeps them in ascending order; at the end of the burst
// the entry at half the valid count is reported, or no_echo when none was
// valid. Measurements are spaced 1000 ticks apart. The block handles one item
// at a time: an accepted item moves through the execute, insert and median-select
// states in that order, and the result is then offered in the output state. With
// the output side always ready the input is ready again right after the edge that
// takes the result. Configuration writes take effect on the next clock edge and
// should be made while no item is in flight.
module ultrasonic_ranger_median_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [urm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_start_req,
    input  logic                           i_echo,
    // Output channel.
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_trig,
    output logic                           o_done_res,
    output logic [urm_pkg::DIST_W-1:0]     o_distance_cm,
    output logic                           o_no_echo
);
    import urm_pkg::*;

    // Configuration registers.
    logic [SC_W-1:0]   r_sample_count;
    logic [TMO_W-1:0]  r_timeout;

    // Handshake sequencer and the captured item.
    t_hs               r_hs, n_hs;
    logic              r_start;
    logic              r_echo;

    // Number of distances currently held in the cell row.
    logic [CNT_W-1:0]  r_vc;

    // Result register.
    logic              r_trig;
    logic              r_done;
    logic [DIST_W-1:0] r_dist;
    logic              r_no_echo;

    t_meas             w_meas;
    logic [DIST_W-1:0] w_q;
    logic              w_step;
    logic              w_ins;
    logic [IDX_W-1:0]  w_mid;

    logic              w_gt  [MAX_SAMPLES];
    logic [DIST_W-1:0] w_val [MAX_SAMPLES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
            r_timeout      <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data[SC_W-1:0];
                REG_TIMEOUT:      r_timeout      <= i_cfg_data[TMO_W-1:0];
                default:          ;
            endcase
        end
    end

    assign o_in_ready  = (r_hs == HS_IDLE);
    assign o_out_valid = (r_hs == HS_OUT);
    assign w_step      = (r_hs == HS_EXEC);

    // The sequencer advances one tick per item; its outcome and the
    // distance product are registered for the insert cycle.
    urm_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_start        (r_start),
        .i_echo         (r_echo),
        .i_sample_count (r_sample_count),
        .i_timeout      (r_timeout),
        .o_meas         (w_meas),
        .o_dist         (w_q)
    );

    // A finished measurement is stored only if its distance is nonzero and
    // the row still has room.
    assign w_ins = (r_hs == HS_INS) && w_meas.store && (w_q != '0)
                   && (r_vc < CNT_W'(MAX_SAMPLES));

    // Row of sorted cells. Each cell compares the new distance with its own
    // value and, when it must move, takes either its left neighbor's value or
    // the new distance.
    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic              w_left_gt;
        logic [DIST_W-1:0] w_left_val;
        if (g == 0) begin : g_first
            assign w_left_gt  = 1'b0;
            assign w_left_val = '0;
        end else begin : g_rest
            assign w_left_gt  = w_gt[g-1];
            assign w_left_val = w_val[g-1];
        end
        urm_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (w_ins),
            .i_d        (w_q),
            .i_occ      (r_vc > CNT_W'(g)),
            .i_at_end   (r_vc == CNT_W'(g)),
            .i_left_gt  (w_left_gt),
            .i_left_val (w_left_val),
            .o_gt       (w_gt[g]),
            .o_val      (w_val[g])
        );
    end

    // Median position: half the valid count, always below the row length.
    assign w_mid = IDX_W'(r_vc >> 1);

    always_comb begin
        n_hs = r_hs;
        case (r_hs)
            HS_IDLE: if (i_in_valid) n_hs = HS_EXEC;
            HS_EXEC: n_hs = HS_INS;
            HS_INS:  n_hs = HS_MED;
            HS_MED:  n_hs = HS_OUT;
            HS_OUT:  if (i_out_ready) n_hs = HS_IDLE;
            default: n_hs = HS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hs <= HS_IDLE;
            r_vc <= '0;
        end else begin
            r_hs <= n_hs;
            if ((r_hs == HS_INS) && w_meas.clear) begin
                r_vc <= '0;
            end else if (w_ins) begin
                r_vc <= CNT_W'(r_vc + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_start <= i_start_req;
            r_echo  <= i_echo;
        end
        if (r_hs == HS_MED) begin
            r_trig    <= w_meas.trig;
            r_done    <= w_meas.done;
            r_no_echo <= w_meas.done && (r_vc == '0);
            r_dist    <= (w_meas.done && (r_vc != '0)) ? w_val[w_mid] : '0;
        end
    end

    assign o_trig        = r_trig;
    assign o_done_res    = r_done;
    assign o_distance_cm = r_dist;
    assign o_no_echo     = r_no_echo;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the ultrasonic ranger median block, with its own tick-level predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import urm_pkg::*;

    // Timing of one measurement as seen in ticks, kept independent of the RTL package.
    localparam int unsigned TRIG_LO_LEN = 2;
    localparam int unsigned TRIG_HI_LEN = 10;
    localparam int unsigned GAP_LEN     = 1000;
    localparam int unsigned CM_DIV      = 58;

    // The receiver's long hold-off, and the cycle count after which the run is declared hung.
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int unsigned MAX_REPORTS = 10;

    // One result item: what the block drives for a single tick.
    typedef struct packed {
        logic              trig;
        logic              done;
        logic [DIST_W-1:0] cm;
        logic              no_echo;
    } t_reading;

    // Tracks the ranger tick by tick, queues the reading each accepted tick must
    // produce, and compares the readings the block hands back in order.
    class ranger_ledger;
        logic [SC_W-1:0]   meas_cfg;
        logic [TMO_W-1:0]  tmo;
        t_phase            stage;
        int unsigned       ticks;
        int unsigned       meas_idx;
        int unsigned       n_valid;
        logic [DIST_W-1:0] rank [MAX_SAMPLES];
        t_reading          readings_due [$];

        int unsigned mismatches;
        int unsigned n_ticks;
        int unsigned n_bursts;
        int unsigned n_medians;
        int unsigned n_silent;
        int unsigned max_cm;

        function new();
            meas_cfg = 4'd5;
            tmo      = 16'd30000;
            stage    = PH_IDLE;
            ticks    = 0;
            meas_idx = 0;
            n_valid  = 0;
            foreach (rank[i]) rank[i] = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SAMPLE_COUNT) meas_cfg = data[SC_W-1:0];
            else if (idx == REG_TIMEOUT) tmo = data[TMO_W-1:0];
        endfunction

        function int unsigned pending();
            return readings_due.size();
        endfunction

        // A zero count still takes one measurement; large counts stop at the store depth.
        function int unsigned burst_len();
            int unsigned n;
            n = meas_cfg;
            if (n == 0) n = 1;
            if (n > MAX_SAMPLES) n = MAX_SAMPLES;
            return n;
        endfunction

        function void insert_ranked(logic [DIST_W-1:0] d);
            int unsigned i;
            if (n_valid >= MAX_SAMPLES) return;
            i = n_valid;
            while (i > 0 && rank[i-1] > d) begin
                rank[i] = rank[i-1];
                i--;
            end
            rank[i] = d;
            n_valid++;
        endfunction

        // Closes a measurement and reports whether the burst result is final.
        function bit close_measurement(bit ok, int unsigned dur);
            int unsigned d;
            if (ok) begin
                d = dur / CM_DIV;
                if (d > 0) insert_ranked(DIST_W'(d));
            end
            meas_idx++;
            ticks = 0;
            if (meas_idx >= burst_len()) begin
                stage = PH_IDLE;
                return 1'b1;
            end
            stage = PH_GAP;
            return 1'b0;
        endfunction

        function void take_tick(bit start, bit echo);
            t_reading    r;
            int unsigned mid;
            r = '0;
            n_ticks++;
            case (stage)
                PH_IDLE: begin
                    if (start) begin
                        meas_idx = 0;
                        n_valid  = 0;
                        ticks    = 0;
                        stage    = PH_TRIG_LOW;
                        n_bursts++;
                    end
                end
                PH_TRIG_LOW: begin
                    ticks++;
                    if (ticks >= TRIG_LO_LEN) begin
                        ticks = 0;
                        stage = PH_TRIG_HIGH;
                    end
                end
                PH_TRIG_HIGH: begin
                    r.trig = 1'b1;
                    ticks++;
                    if (ticks >= TRIG_HI_LEN) begin
                        ticks = 0;
                        stage = PH_WAIT_RISE;
                    end
                end
                PH_WAIT_RISE: begin
                    if (!echo) begin
                        ticks++;
                        if (ticks > tmo) r.done = close_measurement(1'b0, 0);
                    end else begin
                        // The rising tick is already the first high tick.
                        ticks = 1;
                        stage = PH_HIGH;
                        if (ticks > tmo) r.done = close_measurement(1'b0, 0);
                    end
                end
                PH_HIGH: begin
                    if (echo) begin
                        ticks++;
                        if (ticks > tmo) r.done = close_measurement(1'b0, 0);
                    end else begin
                        r.done = close_measurement(1'b1, ticks);
                    end
                end
                PH_GAP: begin
                    ticks++;
                    if (ticks >= GAP_LEN) begin
                        ticks = 0;
                        stage = PH_TRIG_LOW;
                    end
                end
                default: begin
                    stage = PH_IDLE;
                    ticks = 0;
                end
            endcase
            if (r.done) begin
                if (n_valid == 0) begin
                    r.no_echo = 1'b1;
                end else begin
                    mid = n_valid / 2;
                    if (mid >= MAX_SAMPLES) mid = MAX_SAMPLES - 1;
                    r.cm = rank[mid];
                end
            end
            readings_due.push_back(r);
        endfunction

        function void match_reading(logic trig, logic done, logic [DIST_W-1:0] cm,
                                    logic no_echo);
            t_reading want;
            if (readings_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Unexpected reading trig=%b done=%b cm=%0d no_echo=%b",
                             trig, done, cm, no_echo);
                return;
            end
            want = readings_due.pop_front();
            if (trig !== want.trig || done !== want.done || cm !== want.cm ||
                no_echo !== want.no_echo) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Reading mismatch at %0t: expected trig=%b done=%b cm=%0d %s%b, %s",
                             $realtime, want.trig, want.done, want.cm, "no_echo=",
                             want.no_echo, $sformatf("got trig=%b done=%b cm=%0d no_echo=%b",
                             trig, done, cm, no_echo));
            end
            if (want.done) begin
                if (want.no_echo) begin
                    n_silent++;
                end else begin
                    n_medians++;
                    if (want.cm > max_cm) max_cm = want.cm;
                end
            end
        endfunction
    endclass

    // Every input of the block starts from a known value.
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_start_req = 1'b0;
    logic                  i_echo      = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_trig;
    logic                  o_done_res;
    logic [DIST_W-1:0]     o_distance_cm;
    logic                  o_no_echo;

    ranger_ledger ledger;

    // When calm is set, neither side idles. The stimulus raises hold_req once to
    // make the receiver stall for a long stretch while items keep being offered.
    bit          calm       = 1'b0;
    bit          hold_req   = 1'b0;
    int unsigned cycles     = 0;
    int unsigned n_settings = 0;

    ultrasonic_ranger_median_top DUT (.*);

    always #10 i_clk = ~i_clk;

    // The run is declared hung once the cycle count passes a generous bound.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Cycle limit reached with %0d readings still outstanding",
                     ledger.pending());
            $display("** ultrasonic_ranger_median_top: FAILED **");
            $finish;
        end
    end

    // Both handshakes are sampled on the rising edge, before the block updates.
    // An accepted item is predicted first, then any accepted reading is checked
    // against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) ledger.take_tick(i_start_req, i_echo);
            if (o_out_valid && i_out_ready)
                ledger.match_reading(o_trig, o_done_res, o_distance_cm, o_no_echo);
        end
    end

    // Receiver: may hold off for a random stall before each reading, but never while calm.
    // The long hold-off lets the block fill and push back on the input side.
    initial begin : reading_sink
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = calm ? 0 : $urandom_range(0, 3);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            @(negedge i_clk);
        end
    end

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Offers one tick as an item and returns on the falling edge after it is
    // accepted. Valid stays high into the next item when no gap is drawn.
    task automatic send_tick(input bit start, input bit echo);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_start_req <= start;
        i_echo      <= echo;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        @(negedge i_clk);
    endtask

    // Stops offering items and waits until every predicted reading has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes both registers while the block is idle and mirrors them in the ledger.
    task automatic configure(input logic [SC_W-1:0] count, input logic [TMO_W-1:0] limit);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SAMPLE_COUNT;
        i_cfg_data <= CFG_DATA_W'(count);
        ledger.set_register(REG_SAMPLE_COUNT, CFG_DATA_W'(count));
        @(negedge i_clk);
        i_cfg_idx  <= REG_TIMEOUT;
        i_cfg_data <= CFG_DATA_W'(limit);
        ledger.set_register(REG_TIMEOUT, CFG_DATA_W'(limit));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Drives the echo for one measurement once the block waits for the rise.
    // Most echoes are well-formed pulses of a few centimeters; the rest probe
    // the timeout boundaries and pulses too short to yield a distance. Start
    // requests are sprinkled in and must be ignored while busy.
    task automatic one_measurement();
        int unsigned limit;
        int unsigned low_n;
        int unsigned high_n;
        limit  = ledger.tmo;
        low_n  = $urandom_range(0, (limit < 20) ? limit : 20);
        high_n = $urandom_range(CM_DIV, 8 * CM_DIV);
        if (high_n > limit) high_n = limit;
        if (limit <= 1200) begin
            case ($urandom_range(0, 9))
                0:       low_n  = limit + 1;
                1:       high_n = limit + 1;
                2:       low_n  = limit;
                3:       high_n = limit;
                4:       high_n = $urandom_range(1, CM_DIV - 1);
                default: ;
            endcase
        end
        for (int i = 0; i < low_n && ledger.stage == PH_WAIT_RISE; i++)
            send_tick(coin(), 1'b0);
        for (int i = 0; i < high_n &&
             (ledger.stage == PH_WAIT_RISE || ledger.stage == PH_HIGH); i++)
            send_tick(coin(), 1'b1);
        if (ledger.stage == PH_HIGH) send_tick(coin(), 1'b0);
    endtask

    // One full burst from the start request until the ledger is idle again.
    // Trigger and gap ticks carry random echo and start levels as noise.
    task automatic run_burst();
        repeat ($urandom_range(0, 2)) send_tick(1'b0, coin());
        send_tick(1'b1, coin());
        while (ledger.stage != PH_IDLE) begin
            if (ledger.stage == PH_WAIT_RISE) one_measurement();
            else send_tick(coin(), coin());
        end
    endtask

    task automatic run_phase(input logic [SC_W-1:0] count, input logic [TMO_W-1:0] limit,
                             input int unsigned bursts);
        configure(count, limit);
        repeat (bursts) run_burst();
    endtask

    initial begin : stimulus
        ledger = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with a zero sample count and a zero timeout. The first
        // burst holds start high while triggering, which the busy block must ignore,
        // and fails on the first waiting tick. An idle tick without start
        // follows. The second burst fails on the very tick the echo rises.
        configure(4'd0, 16'd0);
        send_tick(1'b1, 1'b1);
        repeat (12) send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        repeat (12) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);

        // Random single-measurement bursts over a few timeouts; each further
        // measurement in a burst would add a 1000-tick gap. The receiver's long
        // stall is requested at the start of the first phase.
        hold_req = 1'b1;
        run_phase(4'd1, 16'($urandom_range(60, 150)), 5);
        run_phase(4'd0, 16'd70, 2);

        // A tiny timeout makes every echo either time out or end too short to
        // give a distance. Both sides run without idling to send items back to back.
        configure(4'd1, 16'd3);
        calm = 1'b1;
        repeat (3) run_burst();
        calm = 1'b0;

        settle();
        repeat (10) @(negedge i_clk);

        $display("Ran %0d bursts over %0d ticks under %0d register settings.",
                 ledger.n_bursts, ledger.n_ticks, n_settings);
        $display("Bursts with a median: %0d (largest %0d cm); bursts with no echo: %0d.",
                 ledger.n_medians, ledger.max_cm, ledger.n_silent);
        if (ledger.pending() != 0)
            $display("%0d predicted readings never arrived", ledger.pending());
        if (ledger.mismatches == 0 && ledger.pending() == 0) begin
            $display("** ultrasonic_ranger_median_top: PASSED **");
        end else begin
            $display("%0d mismatching readings", ledger.mismatches);
            $display("** ultrasonic_ranger_median_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/urm_pkg.sv
rtl/urm_cell.sv
rtl/urm_seq.sv
rtl/ultrasonic_ranger_median_top.sv
bench/tb.sv
